// ----- sv/modls_pkg.sv -----
// Package: shared constants, codes, payload types and modular add/subtract helpers.
`default_nettype none

package modls_pkg;

    localparam int DATA_W           = 32;
    localparam int MAX_UNKNOWNS_DEF = 64;
    localparam logic [DATA_W-1:0] RESET_MODULUS = 32'd2147483647;
    localparam logic [6:0]        RESET_SIZE    = 7'd64;

    // configuration register indexes
    localparam logic CFG_PRIME = 1'b0;
    localparam logic CFG_SIZE  = 1'b1;

    // request codes
    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_SET   = 2'd1;
    localparam logic [1:0] REQ_SOLVE = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [5:0]        row_index;
        logic [5:0]        col_index;
        logic [DATA_W-1:0] residue_in;
    } req_t;

    typedef struct packed {
        logic              status;
        logic [5:0]        unknown_index;
        logic [DATA_W-1:0] residue_out;
        logic              last;
    } res_t;

    // (x + y) mod m for x, y below m
    function automatic logic [DATA_W-1:0] addmod(input logic [DATA_W-1:0] x,
                                                 input logic [DATA_W-1:0] y,
                                                 input logic [DATA_W-1:0] m);
        logic [DATA_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[DATA_W-1:0];
    endfunction

    // (x - y) mod m for x, y below m
    function automatic logic [DATA_W-1:0] submod(input logic [DATA_W-1:0] x,
                                                 input logic [DATA_W-1:0] y,
                                                 input logic [DATA_W-1:0] m);
        logic [DATA_W:0] s;
        if (x >= y)
        begin
            s = {1'b0, x} - {1'b0, y};
        end
        else
        begin
            s = {1'b0, x} + {1'b0, m} - {1'b0, y};
        end
        return s[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- sv/modls_if.sv -----
// Interfaces: request and result channels with valid/ready handshake.
`default_nettype none

interface modls_req_if;
    logic               valid;
    logic               ready;
    modls_pkg::req_t    payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface modls_res_if;
    logic               valid;
    logic               ready;
    modls_pkg::res_t    payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- sv/modls_mulmod.sv -----
// Bit-serial modular multiplier: a*b mod m, one bit of b per cycle.
`default_nettype none

module modls_mulmod (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [modls_pkg::DATA_W-1:0]  a,
    input  wire logic [modls_pkg::DATA_W-1:0]  b,
    input  wire logic [modls_pkg::DATA_W-1:0]  m,
    output logic                               done,
    output logic [modls_pkg::DATA_W-1:0]       p
);

    localparam int DW   = modls_pkg::DATA_W;
    localparam int CNTW = $clog2(DW);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [DW-1:0]   a_reg;
    logic [DW-1:0]   b_reg;
    logic [DW-1:0]   acc_reg;
    logic [DW-1:0]   acc_next;

    // double, then add a when the current multiplier bit is set
    assign acc_next = modls_pkg::addmod(modls_pkg::addmod(acc_reg, acc_reg, m),
                                        b_reg[DW-1] ? a_reg : '0, m);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNTW'(1);
            if (cnt_reg == CNTW'(DW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= b_reg << 1;
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

`default_nettype wire

// ----- sv/modp_linear_system_solver_top.sv -----
// Top level: Gaussian elimination mod p over a matrix memory with a shared multiplier.
// Load: a right-hand-side set reduces its value in the multiplier and writes it; a cell add
//   also reduces the stored cell and writes back the modular sum.
// Solve: every modular product goes through the one bit-serial multiplier.
// One item in flight; ready only while the sequencer is idle.
// Reset and every finished solve sweep the matrix memory clean, all MAX_UNKNOWNS*(MAX_UNKNOWNS+1)
//   cells (4160 at 64); no item is accepted during the sweep.
`default_nettype none

module modp_linear_system_solver_top #(
    parameter int MAX_UNKNOWNS = modls_pkg::MAX_UNKNOWNS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_index,
    input  wire logic [modls_pkg::DATA_W-1:0] cfg_data,
    modls_req_if.sink                         req,
    modls_res_if.source                       res
);

    localparam int DW         = modls_pkg::DATA_W;
    localparam int CW         = $clog2(MAX_UNKNOWNS + 1);
    localparam int SW         = (MAX_UNKNOWNS > 1) ? $clog2(MAX_UNKNOWNS) : 1;
    localparam int STORE_COLS = MAX_UNKNOWNS + 1;
    localparam int DEPTH      = MAX_UNKNOWNS * STORE_COLS;
    localparam int AW         = $clog2(DEPTH);

    typedef enum logic [33:0] {
        S_CLR      = 34'd1 << 0,
        S_IDLE     = 34'd1 << 1,
        S_MUL      = 34'd1 << 2,
        S_LD_VDONE = 34'd1 << 3,
        S_LD_CGO   = 34'd1 << 4,
        S_LD_CWR   = 34'd1 << 5,
        S_NR_RD    = 34'd1 << 6,
        S_NR_GO    = 34'd1 << 7,
        S_NR_WR    = 34'd1 << 8,
        S_PV_RD    = 34'd1 << 9,
        S_PV_CHK   = 34'd1 << 10,
        S_SW_RD1   = 34'd1 << 11,
        S_SW_RD2   = 34'd1 << 12,
        S_SW_W1    = 34'd1 << 13,
        S_SW_W2    = 34'd1 << 14,
        S_PW_SQ    = 34'd1 << 15,
        S_PW_ML    = 34'd1 << 16,
        S_PW_NX    = 34'd1 << 17,
        S_SC_RD    = 34'd1 << 18,
        S_SC_GO    = 34'd1 << 19,
        S_SC_WR    = 34'd1 << 20,
        S_EL_RDF   = 34'd1 << 21,
        S_EL_F     = 34'd1 << 22,
        S_EL_RDK   = 34'd1 << 23,
        S_EL_RDR   = 34'd1 << 24,
        S_EL_WR    = 34'd1 << 25,
        S_BS_INIT  = 34'd1 << 26,
        S_BS_RD    = 34'd1 << 27,
        S_BS_GO    = 34'd1 << 28,
        S_BS_ACC   = 34'd1 << 29,
        S_BS_WR    = 34'd1 << 30,
        S_OUT_RD   = 34'd1 << 31,
        S_OUT_LD   = 34'd1 << 32,
        S_SING     = 34'd1 << 33
    } state_t;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] row,
                                                 input logic [CW-1:0] col);
        return AW'(int'(row) * STORE_COLS + int'(col));
    endfunction

    // column n of the active system is the right-hand side, stored in the last column
    function automatic logic [CW-1:0] col_of(input logic [CW-1:0] col,
                                             input logic [CW-1:0] n);
        return (col == n) ? CW'(MAX_UNKNOWNS) : col;
    endfunction

    // control registers
    state_t          state_reg, state_next;
    state_t          ret_reg, ret_next;
    logic            out_valid_reg, out_valid_next;
    logic [DW-1:0]   prime_reg, prime_next;
    logic [6:0]      size_reg, size_next;
    logic [AW-1:0]   clr_reg, clr_next;

    // datapath registers
    logic [1:0]      type_reg, type_next;
    logic [CW-1:0]   r_reg, r_next;
    logic [CW-1:0]   c_reg, c_next;
    logic [CW-1:0]   k_reg, k_next;
    logic [CW-1:0]   piv_reg, piv_next;
    logic [CW-1:0]   n_reg, n_next;
    logic [DW-1:0]   vred_reg, vred_next;
    logic [DW-1:0]   f_reg, f_next;
    logic [DW-1:0]   tmp_reg, tmp_next;
    logic [DW-1:0]   pivval_reg, pivval_next;
    logic [DW-1:0]   res_reg, res_next;
    logic [DW-1:0]   tot_reg, tot_next;
    logic [4:0]      bit_reg, bit_next;
    modls_pkg::res_t out_data_reg, out_data_next;

    // memories
    logic [DW-1:0]   mat_mem [DEPTH];
    logic [DW-1:0]   mat_rdata_reg;
    logic            mat_re, mat_we;
    logic [AW-1:0]   mat_raddr, mat_waddr;
    logic [DW-1:0]   mat_wdata;
    logic [DW-1:0]   sol_mem [MAX_UNKNOWNS];
    logic [DW-1:0]   sol_rdata_reg;
    logic            sol_re, sol_we;
    logic [SW-1:0]   sol_raddr, sol_waddr;
    logic [DW-1:0]   sol_wdata;

    // multiplier
    logic            mm_start, mm_done;
    logic [DW-1:0]   mm_a, mm_b, mm_prod;

    logic [DW-1:0]   mod_m;
    logic [DW-1:0]   exp_m;
    logic [CW-1:0]   eff_n;
    logic [CW-1:0]   n_last;

    assign mod_m  = (prime_reg < 32'd2) ? 32'd2 : prime_reg;
    assign exp_m  = mod_m - 32'd2;
    assign n_last = n_reg - CW'(1);

    always_comb
    begin
        if (size_reg == 7'd0)
        begin
            eff_n = CW'(1);
        end
        else if (int'(size_reg) > MAX_UNKNOWNS)
        begin
            eff_n = CW'(MAX_UNKNOWNS);
        end
        else
        begin
            eff_n = CW'(size_reg);
        end
    end

    modls_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm_start),
        .a     (mm_a),
        .b     (mm_b),
        .m     (mod_m),
        .done  (mm_done),
        .p     (mm_prod)
    );

    assign req.ready   = (state_reg == S_IDLE);
    assign res.valid   = out_valid_reg;
    assign res.payload = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        out_valid_next = out_valid_reg && !res.ready;
        prime_next     = prime_reg;
        size_next      = size_reg;
        clr_next       = clr_reg;
        type_next      = type_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        k_next         = k_reg;
        piv_next       = piv_reg;
        n_next         = n_reg;
        vred_next      = vred_reg;
        f_next         = f_reg;
        tmp_next       = tmp_reg;
        pivval_next    = pivval_reg;
        res_next       = res_reg;
        tot_next       = tot_reg;
        bit_next       = bit_reg;
        out_data_next  = out_data_reg;
        mat_re         = 1'b0;
        mat_raddr      = cell_addr(r_reg, col_of(c_reg, n_reg));
        mat_we         = 1'b0;
        mat_waddr      = cell_addr(r_reg, col_of(c_reg, n_reg));
        mat_wdata      = mm_prod;
        sol_re         = 1'b0;
        sol_raddr      = c_reg[SW-1:0];
        sol_we         = 1'b0;
        sol_waddr      = r_reg[SW-1:0];
        sol_wdata      = modls_pkg::submod(mat_rdata_reg, tot_reg, mod_m);
        mm_start       = 1'b0;
        mm_a           = DW'(1);
        mm_b           = mat_rdata_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                modls_pkg::CFG_PRIME: prime_next = cfg_data;
                modls_pkg::CFG_SIZE:  size_next  = cfg_data[6:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_CLR:
            begin
                mat_we    = 1'b1;
                mat_waddr = clr_reg;
                mat_wdata = '0;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    type_next = req.payload.req_type;
                    r_next    = CW'(req.payload.row_index);
                    c_next    = CW'(req.payload.col_index);
                    unique case (req.payload.req_type)
                        modls_pkg::REQ_ADD:
                        begin
                            if (int'(req.payload.row_index) < MAX_UNKNOWNS &&
                                int'(req.payload.col_index) < MAX_UNKNOWNS)
                            begin
                                mm_start   = 1'b1;
                                mm_b       = req.payload.residue_in;
                                ret_next   = S_LD_VDONE;
                                state_next = S_MUL;
                            end
                        end
                        modls_pkg::REQ_SET:
                        begin
                            if (int'(req.payload.row_index) < MAX_UNKNOWNS)
                            begin
                                mm_start   = 1'b1;
                                mm_b       = req.payload.residue_in;
                                ret_next   = S_LD_VDONE;
                                state_next = S_MUL;
                            end
                        end
                        modls_pkg::REQ_SOLVE:
                        begin
                            n_next     = eff_n;
                            r_next     = '0;
                            c_next     = '0;
                            state_next = S_NR_RD;
                        end
                        default: ;
                    endcase
                end
            end

            S_MUL:
            begin
                if (mm_done)
                begin
                    state_next = ret_reg;
                end
            end

            S_LD_VDONE:
            begin
                vred_next = mm_prod;
                if (type_reg == modls_pkg::REQ_SET)
                begin
                    mat_we     = 1'b1;
                    mat_waddr  = cell_addr(r_reg, CW'(MAX_UNKNOWNS));
                    state_next = S_IDLE;
                end
                else
                begin
                    mat_re     = 1'b1;
                    mat_raddr  = cell_addr(r_reg, c_reg);
                    state_next = S_LD_CGO;
                end
            end

            S_LD_CGO:
            begin
                mm_start   = 1'b1;
                ret_next   = S_LD_CWR;
                state_next = S_MUL;
            end

            S_LD_CWR:
            begin
                mat_we     = 1'b1;
                mat_waddr  = cell_addr(r_reg, c_reg);
                mat_wdata  = modls_pkg::addmod(mm_prod, vred_reg, mod_m);
                state_next = S_IDLE;
            end

            // reduce every active cell under the current modulus
            S_NR_RD:
            begin
                mat_re     = 1'b1;
                state_next = S_NR_GO;
            end

            S_NR_GO:
            begin
                mm_start   = 1'b1;
                ret_next   = S_NR_WR;
                state_next = S_MUL;
            end

            S_NR_WR:
            begin
                mat_we = 1'b1;
                if (c_reg == n_reg)
                begin
                    c_next = '0;
                    if (r_reg == n_last)
                    begin
                        r_next     = '0;
                        k_next     = '0;
                        state_next = S_PV_RD;
                    end
                    else
                    begin
                        r_next     = r_reg + CW'(1);
                        state_next = S_NR_RD;
                    end
                end
                else
                begin
                    c_next     = c_reg + CW'(1);
                    state_next = S_NR_RD;
                end
            end

            S_PV_RD:
            begin
                mat_re     = 1'b1;
                mat_raddr  = cell_addr(r_reg, k_reg);
                state_next = S_PV_CHK;
            end

            S_PV_CHK:
            begin
                if (mat_rdata_reg != '0)
                begin
                    piv_next    = r_reg;
                    pivval_next = mat_rdata_reg;
                    c_next      = k_reg;
                    res_next    = DW'(1);
                    bit_next    = 5'd31;
                    state_next  = (r_reg != k_reg) ? S_SW_RD1 : S_PW_SQ;
                end
                else if (r_reg == n_last)
                begin
                    state_next = S_SING;
                end
                else
                begin
                    r_next     = r_reg + CW'(1);
                    state_next = S_PV_RD;
                end
            end

            S_SW_RD1:
            begin
                mat_re     = 1'b1;
                mat_raddr  = cell_addr(k_reg, col_of(c_reg, n_reg));
                state_next = S_SW_RD2;
            end

            S_SW_RD2:
            begin
                tmp_next   = mat_rdata_reg;
                mat_re     = 1'b1;
                mat_raddr  = cell_addr(piv_reg, col_of(c_reg, n_reg));
                state_next = S_SW_W1;
            end

            S_SW_W1:
            begin
                mat_we     = 1'b1;
                mat_waddr  = cell_addr(k_reg, col_of(c_reg, n_reg));
                mat_wdata  = mat_rdata_reg;
                state_next = S_SW_W2;
            end

            S_SW_W2:
            begin
                mat_we    = 1'b1;
                mat_waddr = cell_addr(piv_reg, col_of(c_reg, n_reg));
                mat_wdata = tmp_reg;
                if (c_reg == n_reg)
                begin
                    state_next = S_PW_SQ;
                end
                else
                begin
                    c_next     = c_reg + CW'(1);
                    state_next = S_SW_RD1;
                end
            end

            // inverse of the pivot as pivot^(m-2), exponent bits high to low
            S_PW_SQ:
            begin
                mm_start   = 1'b1;
                mm_a       = res_reg;
                mm_b       = res_reg;
                ret_next   = S_PW_ML;
                state_next = S_MUL;
            end

            S_PW_ML:
            begin
                res_next = mm_prod;
                if (exp_m[bit_reg])
                begin
                    mm_start   = 1'b1;
                    mm_a       = mm_prod;
                    mm_b       = pivval_reg;
                    ret_next   = S_PW_NX;
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_PW_NX;
                end
            end

            S_PW_NX:
            begin
                res_next = mm_prod;
                if (bit_reg == 5'd0)
                begin
                    c_next     = k_reg;
                    state_next = S_SC_RD;
                end
                else
                begin
                    bit_next   = bit_reg - 5'd1;
                    state_next = S_PW_SQ;
                end
            end

            S_SC_RD:
            begin
                mat_re     = 1'b1;
                mat_raddr  = cell_addr(k_reg, col_of(c_reg, n_reg));
                state_next = S_SC_GO;
            end

            S_SC_GO:
            begin
                mm_start   = 1'b1;
                mm_a       = mat_rdata_reg;
                mm_b       = res_reg;
                ret_next   = S_SC_WR;
                state_next = S_MUL;
            end

            S_SC_WR:
            begin
                mat_we    = 1'b1;
                mat_waddr = cell_addr(k_reg, col_of(c_reg, n_reg));
                if (c_reg == n_reg)
                begin
                    if (k_reg == n_last)
                    begin
                        state_next = S_BS_INIT;
                    end
                    else
                    begin
                        r_next     = k_reg + CW'(1);
                        state_next = S_EL_RDF;
                    end
                end
                else
                begin
                    c_next     = c_reg + CW'(1);
                    state_next = S_SC_RD;
                end
            end

            S_EL_RDF:
            begin
                mat_re     = 1'b1;
                mat_raddr  = cell_addr(r_reg, k_reg);
                state_next = S_EL_F;
            end

            S_EL_F:
            begin
                f_next = mat_rdata_reg;
                if (mat_rdata_reg == '0)
                begin
                    // skip the row, or advance to the next column
                    if (r_reg == n_last)
                    begin
                        k_next     = k_reg + CW'(1);
                        r_next     = k_reg + CW'(1);
                        state_next = S_PV_RD;
                    end
                    else
                    begin
                        r_next     = r_reg + CW'(1);
                        state_next = S_EL_RDF;
                    end
                end
                else
                begin
                    mat_we     = 1'b1;
                    mat_waddr  = cell_addr(r_reg, k_reg);
                    mat_wdata  = '0;
                    c_next     = k_reg + CW'(1);
                    state_next = S_EL_RDK;
                end
            end

            S_EL_RDK:
            begin
                mat_re     = 1'b1;
                mat_raddr  = cell_addr(k_reg, col_of(c_reg, n_reg));
                state_next = S_EL_RDR;
            end

            S_EL_RDR:
            begin
                mat_re     = 1'b1;
                mm_start   = 1'b1;
                mm_a       = mat_rdata_reg;
                mm_b       = f_reg;
                ret_next   = S_EL_WR;
                state_next = S_MUL;
            end

            S_EL_WR:
            begin
                mat_we    = 1'b1;
                mat_wdata = modls_pkg::submod(mat_rdata_reg, mm_prod, mod_m);
                if (c_reg == n_reg)
                begin
                    if (r_reg == n_last)
                    begin
                        k_next     = k_reg + CW'(1);
                        r_next     = k_reg + CW'(1);
                        state_next = S_PV_RD;
                    end
                    else
                    begin
                        r_next     = r_reg + CW'(1);
                        state_next = S_EL_RDF;
                    end
                end
                else
                begin
                    c_next     = c_reg + CW'(1);
                    state_next = S_EL_RDK;
                end
            end

            S_BS_INIT:
            begin
                r_next     = n_last;
                c_next     = n_reg;
                tot_next   = '0;
                state_next = S_BS_RD;
            end

            // at the right-hand side column, fetch it and finish the unknown
            S_BS_RD:
            begin
                mat_re = 1'b1;
                if (c_reg == n_reg)
                begin
                    state_next = S_BS_WR;
                end
                else
                begin
                    sol_re     = 1'b1;
                    state_next = S_BS_GO;
                end
            end

            S_BS_GO:
            begin
                mm_start   = 1'b1;
                mm_a       = mat_rdata_reg;
                mm_b       = sol_rdata_reg;
                ret_next   = S_BS_ACC;
                state_next = S_MUL;
            end

            S_BS_ACC:
            begin
                tot_next   = modls_pkg::addmod(tot_reg, mm_prod, mod_m);
                c_next     = c_reg + CW'(1);
                state_next = S_BS_RD;
            end

            S_BS_WR:
            begin
                sol_we = 1'b1;
                if (r_reg == '0)
                begin
                    k_next     = '0;
                    state_next = S_OUT_RD;
                end
                else
                begin
                    r_next     = r_reg - CW'(1);
                    c_next     = r_reg;
                    tot_next   = '0;
                    state_next = S_BS_RD;
                end
            end

            S_OUT_RD:
            begin
                if (!out_valid_reg)
                begin
                    sol_re     = 1'b1;
                    sol_raddr  = k_reg[SW-1:0];
                    state_next = S_OUT_LD;
                end
            end

            S_OUT_LD:
            begin
                out_valid_next              = 1'b1;
                out_data_next.status        = 1'b0;
                out_data_next.unknown_index = 6'(k_reg);
                out_data_next.residue_out   = sol_rdata_reg;
                out_data_next.last          = (k_reg == n_last);
                if (k_reg == n_last)
                begin
                    clr_next   = '0;
                    state_next = S_CLR;
                end
                else
                begin
                    k_next     = k_reg + CW'(1);
                    state_next = S_OUT_RD;
                end
            end

            S_SING:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.status        = 1'b1;
                    out_data_next.unknown_index = 6'(k_reg);
                    out_data_next.residue_out   = '0;
                    out_data_next.last          = 1'b1;
                    clr_next                    = '0;
                    state_next                  = S_CLR;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            ret_reg       <= S_IDLE;
            out_valid_reg <= 1'b0;
            prime_reg     <= modls_pkg::RESET_MODULUS;
            size_reg      <= modls_pkg::RESET_SIZE;
            clr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
            prime_reg     <= prime_next;
            size_reg      <= size_next;
            clr_reg       <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg     <= type_next;
        r_reg        <= r_next;
        c_reg        <= c_next;
        k_reg        <= k_next;
        piv_reg      <= piv_next;
        n_reg        <= n_next;
        vred_reg     <= vred_next;
        f_reg        <= f_next;
        tmp_reg      <= tmp_next;
        pivval_reg   <= pivval_next;
        res_reg      <= res_next;
        tot_reg      <= tot_next;
        bit_reg      <= bit_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mat_we)
        begin
            mat_mem[mat_waddr] <= mat_wdata;
        end
        if (mat_re)
        begin
            mat_rdata_reg <= mat_mem[mat_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sol_we)
        begin
            sol_mem[sol_waddr] <= sol_wdata;
        end
        if (sol_re)
        begin
            sol_rdata_reg <= sol_mem[sol_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/modls_checker.sv -----
// Checker: port-level assertions on the solver, bound to the top level.
`default_nettype none

module modls_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            in_valid,
    input wire logic            in_ready,
    input wire logic [1:0]      in_type,
    input wire logic            out_valid,
    input wire logic            out_ready,
    input wire modls_pkg::res_t out_data
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_sing_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status |-> out_data.last)
        else $error("singular status without last");

    a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_type == modls_pkg::REQ_SOLVE |=> !in_ready)
        else $error("ready right after a solve transfer");

    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_ready)
        else $error("result appeared while idle");

endmodule

bind modp_linear_system_solver_top modls_checker u_modls_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_type   (req.payload.req_type),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_data  (res.payload)
);

`default_nettype wire

// ----- bench/modp_linear_system_solver_top_tb.sv -----
// Testbench for the mod-p linear system solver: directed table, then randomized systems.
`timescale 1ns / 100ps

module modp_linear_system_solver_top_tb;

    localparam logic [1:0] REQ_NONE = 2'd3;      // unused code, ignored by the block
    localparam int STORE_N    = 64;
    localparam int RHS_COL    = 64;
    localparam int IDLE_PAUSE = 5000;            // covers a clearing sweep plus one load
    localparam longint CYCLE_LIMIT = 10_000_000;
    localparam int ITEM_GOAL  = 400;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic              cfg_idx;
        logic [31:0]       cfg_val;
        modls_pkg::req_t   item;
        bit                typed;
        modls_pkg::res_t   want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [modls_pkg::DATA_W-1:0] cfg_data = '0;

    modls_req_if req_ch ();
    modls_res_if res_ch ();

    modp_linear_system_solver_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .res       (res_ch)
    );

    always #10 clk = ~clk;

    // solver state as the block should hold it
    bit [31:0] coef_store [STORE_N][STORE_N+1];
    bit [31:0] solution [STORE_N];
    bit [31:0] modulus_reg;
    bit [6:0]  size_reg;

    modls_pkg::res_t solution_q [$];
    int        fail_count = 0;
    int        items_sent = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        hold_left = 0;
    longint    cycle_count = 0;
    stim_row_t table_q [$];

    function automatic bit [63:0] eff_modulus();
        return (modulus_reg < 2) ? 64'd2 : {32'd0, modulus_reg};
    endfunction

    function automatic int eff_size();
        int n;
        n = int'(size_reg);
        if (n < 1) n = 1;
        if (n > STORE_N) n = STORE_N;
        return n;
    endfunction

    function automatic bit [63:0] power_mod(bit [63:0] base, bit [63:0] e, bit [63:0] m);
        bit [63:0] acc;
        acc = 64'd1 % m;
        base = base % m;
        while (e != 0)
        begin
            if (e[0]) acc = (acc * base) % m;
            base = (base * base) % m;
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic int col_of(int c, int n);
        return (c == n) ? RHS_COL : c;
    endfunction

    function automatic void clear_store();
        foreach (coef_store[r, c]) coef_store[r][c] = '0;
    endfunction

    function automatic void eliminate_and_queue();
        bit [63:0] m, inv, f, sub, cur, total, rhs;
        bit [31:0] t;
        modls_pkg::res_t r_out;
        int        n, piv;
        m = eff_modulus();
        n = eff_size();
        for (int r = 0; r < n; r++)
            for (int c = 0; c <= n; c++)
                coef_store[r][col_of(c, n)] = 32'(coef_store[r][col_of(c, n)] % m);
        for (int k = 0; k < n; k++)
        begin
            piv = n;
            for (int r = k; r < n; r++)
                if (coef_store[r][k] != 0)
                begin
                    piv = r;
                    break;
                end
            if (piv == n)
            begin
                r_out.status = 1'b1;
                r_out.unknown_index = k[5:0];
                r_out.residue_out = '0;
                r_out.last = 1'b1;
                solution_q = {solution_q, r_out};
                clear_store();
                return;
            end
            if (piv != k)
                for (int c = k; c <= n; c++)
                begin
                    t = coef_store[k][col_of(c, n)];
                    coef_store[k][col_of(c, n)] = coef_store[piv][col_of(c, n)];
                    coef_store[piv][col_of(c, n)] = t;
                end
            inv = power_mod({32'd0, coef_store[k][k]}, m - 64'd2, m);
            for (int c = k; c <= n; c++)
                coef_store[k][col_of(c, n)] =
                    32'(({32'd0, coef_store[k][col_of(c, n)]} * inv) % m);
            for (int r = k + 1; r < n; r++)
            begin
                f = {32'd0, coef_store[r][k]};
                if (f == 0) continue;
                coef_store[r][k] = '0;
                for (int c = k + 1; c <= n; c++)
                begin
                    sub = (f * {32'd0, coef_store[k][col_of(c, n)]}) % m;
                    cur = {32'd0, coef_store[r][col_of(c, n)]};
                    coef_store[r][col_of(c, n)] =
                        32'((cur >= sub) ? cur - sub : cur + m - sub);
                end
            end
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            total = 0;
            for (int c = i + 1; c < n; c++)
                total = (total + {32'd0, coef_store[i][c]} * {32'd0, solution[c]}) % m;
            rhs = {32'd0, coef_store[i][RHS_COL]};
            solution[i] = 32'((rhs >= total) ? rhs - total : rhs + m - total);
        end
        for (int k = 0; k < n; k++)
        begin
            r_out.status = 1'b0;
            r_out.unknown_index = k[5:0];
            r_out.residue_out = solution[k];
            r_out.last = (k == n - 1);
            solution_q = {solution_q, r_out};
        end
        clear_store();
    endfunction

    function automatic void apply_request(modls_pkg::req_t it);
        bit [63:0] m, v;
        m = eff_modulus();
        v = {32'd0, it.residue_in} % m;
        case (it.req_type)
            modls_pkg::REQ_ADD: coef_store[it.row_index][it.col_index] =
                32'(({32'd0, coef_store[it.row_index][it.col_index]} + v) % m);
            modls_pkg::REQ_SET: coef_store[it.row_index][RHS_COL] = v[31:0];
            modls_pkg::REQ_SOLVE: eliminate_and_queue();
            default: ;
        endcase
    endfunction

    function automatic void check_result(modls_pkg::res_t got);
        modls_pkg::res_t want;
        if (solution_q.size() == 0)
        begin
            $error("unexpected result: status %0d unknown_index %0d residue_out %0d last %0d",
                   got.status, got.unknown_index, got.residue_out, got.last);
            fail_count++;
            return;
        end
        want = solution_q.pop_front();
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            fail_count++;
        end
        if (got.unknown_index !== want.unknown_index)
        begin
            $error("unknown_index: expected %0d, actual %0d",
                   want.unknown_index, got.unknown_index);
            fail_count++;
        end
        if (got.residue_out !== want.residue_out)
        begin
            $error("residue_out: expected %0d, actual %0d", want.residue_out, got.residue_out);
            fail_count++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            fail_count++;
        end
    endfunction

    // called at a falling edge; returns at a falling edge after the transfer
    task automatic send_request(modls_pkg::req_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload <= it;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        apply_request(it);
        if (it.req_type != REQ_NONE) items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        wait (solution_q.size() == 0);
        @(negedge clk);
        repeat (IDLE_PAUSE) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == modls_pkg::CFG_PRIME) modulus_reg = val;
        else size_reg = val[6:0];
    endtask

    function automatic modls_pkg::req_t mk_req(logic [1:0] t, int r, int c, logic [31:0] v);
        modls_pkg::req_t it;
        it.req_type = t;
        it.row_index = r[5:0];
        it.col_index = c[5:0];
        it.residue_in = v;
        return it;
    endfunction

    function automatic void add_cfg(logic idx, logic [31:0] val);
        stim_row_t row;
        row = '{kind: ROW_CFG, default: '0};
        row.cfg_idx = idx;
        row.cfg_val = val;
        table_q = {table_q, row};
    endfunction

    function automatic void add_item(logic [1:0] t, int r, int c, logic [31:0] v);
        stim_row_t row;
        row = '{kind: ROW_ITEM, default: '0};
        row.item = mk_req(t, r, c, v);
        table_q = {table_q, row};
    endfunction

    function automatic void add_singular(int col);
        stim_row_t row;
        row = '{kind: ROW_ITEM, default: '0};
        row.item = mk_req(modls_pkg::REQ_SOLVE, 0, 0, 0);
        row.typed = 1'b1;
        row.want.status = 1'b1;
        row.want.unknown_index = col[5:0];
        row.want.residue_out = '0;
        row.want.last = 1'b1;
        table_q = {table_q, row};
    endfunction

    function automatic logic [31:0] pick_residue();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(16);
            default: return $urandom;
        endcase
    endfunction

    task automatic pick_config();
        logic [31:0] primes [12] = '{32'd2, 32'd3, 32'd5, 32'd7, 32'd13, 32'd65521,
                                     32'd2147483647, 32'd4294967291, 32'hFFFF_FFFF,
                                     32'd0, 32'd1, 32'd12};
        write_reg(modls_pkg::CFG_PRIME, primes[$urandom_range(11)]);
        write_reg(modls_pkg::CFG_SIZE, ($urandom_range(9) == 0) ? $urandom_range(5, 6)
                                                                : $urandom_range(0, 4));
    endtask

    // loads for every equation in use, some noise, then the solve
    task automatic run_system(bit change_mid);
        int n;
        n = eff_size();
        for (int r = 0; r < n; r++)
        begin
            for (int c = 0; c < n; c++)
            begin
                if ($urandom_range(9) < 8)
                    send_request(mk_req(modls_pkg::REQ_ADD, r, c, pick_residue()));
                if ($urandom_range(9) == 0)
                    send_request(mk_req(modls_pkg::REQ_ADD, r, c, pick_residue()));
            end
            send_request(mk_req(modls_pkg::REQ_SET, r, $urandom_range(63), pick_residue()));
            if ($urandom_range(9) == 0)
                send_request(mk_req(REQ_NONE, $urandom_range(63), $urandom_range(63), $urandom));
            if ($urandom_range(9) == 0)
                send_request(mk_req(($urandom_range(1) == 0) ? modls_pkg::REQ_ADD
                                                             : modls_pkg::REQ_SET,
                                    $urandom_range(n, 63), $urandom_range(63), $urandom));
            if (change_mid && r == 0)
            begin
                write_reg(modls_pkg::CFG_PRIME,
                          ($urandom_range(1) == 0) ? 32'd2147483647 : 32'd13);
                @(negedge clk);
            end
        end
        send_request(mk_req(modls_pkg::REQ_SOLVE, $urandom_range(63), $urandom_range(63),
                            $urandom));
    endtask

    // result side: random stalls plus one long hold-off
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            check_result(res_ch.payload);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int rounds;
        req_ch.valid <= 1'b0;
        req_ch.payload <= '0;
        modulus_reg = modls_pkg::RESET_MODULUS;
        size_reg = modls_pkg::RESET_SIZE;
        clear_store();

        // empty store after reset: no pivot in the first column
        add_singular(0);
        add_cfg(modls_pkg::CFG_SIZE, 1);
        add_cfg(modls_pkg::CFG_PRIME, 7);
        add_item(modls_pkg::REQ_ADD, 0, 0, 32'hFFFF_FFFF);
        add_item(modls_pkg::REQ_SET, 0, 0, 32'd5);
        add_item(modls_pkg::REQ_SOLVE, 0, 0, 0);
        // size zero acts as one
        add_cfg(modls_pkg::CFG_SIZE, 0);
        add_item(modls_pkg::REQ_ADD, 0, 0, 32'd1);
        add_item(modls_pkg::REQ_SET, 0, 0, 32'hFFFF_FFFF);
        add_item(modls_pkg::REQ_SOLVE, 0, 0, 0);
        // modulus zero acts as two; row swap needed, load beyond size, unused code
        add_cfg(modls_pkg::CFG_PRIME, 0);
        add_cfg(modls_pkg::CFG_SIZE, 2);
        add_item(modls_pkg::REQ_ADD, 0, 1, 32'd1);
        add_item(modls_pkg::REQ_ADD, 1, 0, 32'd3);
        add_item(modls_pkg::REQ_SET, 1, 0, 32'd1);
        add_item(modls_pkg::REQ_ADD, 63, 63, 32'd5);
        add_item(REQ_NONE, 0, 0, 32'd9);
        add_item(modls_pkg::REQ_SOLVE, 0, 0, 0);
        // no pivot in the second column
        add_cfg(modls_pkg::CFG_PRIME, 7);
        add_item(modls_pkg::REQ_ADD, 0, 0, 32'd1);
        add_item(modls_pkg::REQ_ADD, 1, 0, 32'd1);
        add_singular(1);
        // modulus changed between loads, then a composite modulus
        add_cfg(modls_pkg::CFG_PRIME, 13);
        add_item(modls_pkg::REQ_ADD, 0, 0, 32'd100);
        add_cfg(modls_pkg::CFG_PRIME, 11);
        add_item(modls_pkg::REQ_ADD, 1, 1, 32'd100);
        add_item(modls_pkg::REQ_SET, 0, 0, 32'd77);
        add_item(modls_pkg::REQ_SOLVE, 0, 0, 0);
        add_cfg(modls_pkg::CFG_PRIME, 32'hFFFF_FFFF);
        add_item(modls_pkg::REQ_ADD, 0, 0, 32'd1);
        add_item(modls_pkg::REQ_ADD, 1, 1, 32'hFFFF_FFFE);
        add_item(modls_pkg::REQ_SET, 1, 0, 32'd3);
        add_item(modls_pkg::REQ_SOLVE, 0, 0, 0);
        // size above the store saturates; modulus one acts as two
        add_cfg(modls_pkg::CFG_PRIME, 1);
        add_cfg(modls_pkg::CFG_SIZE, 127);
        add_singular(0);
        add_cfg(modls_pkg::CFG_SIZE, 64);
        add_singular(0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_idle_pct = 26;
        recv_idle_pct = 66;
        foreach (table_q[i])
        begin
            if (table_q[i].kind == ROW_CFG)
            begin
                write_reg(table_q[i].cfg_idx, table_q[i].cfg_val);
            end
            else
            begin
                int before_n;
                before_n = solution_q.size();
                send_request(table_q[i].item);
                if (table_q[i].typed)
                begin
                    while (solution_q.size() > before_n) void'(solution_q.pop_back());
                    solution_q = {solution_q, table_q[i].want};
                end
            end
        end

        rounds = 0;
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 66 : 0;
            recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 26 : 0;
            pick_config();
            while (items_sent < ITEM_GOAL * (phase + 1) / 3 + table_q.size())
            begin
                rounds++;
                if (rounds % 3 == 0 && rounds != 5) pick_config();
                run_system($urandom_range(9) == 0);
                // hold results back long enough that the next loads back up
                if (rounds == 4) hold_left = 30000;
            end
        end
        req_ch.valid <= 1'b0;

        wait (solution_q.size() == 0);
        repeat (IDLE_PAUSE) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/modls_pkg.sv
sv/modls_if.sv
sv/modls_mulmod.sv
sv/modp_linear_system_solver_top.sv
sv/modls_checker.sv
bench/modp_linear_system_solver_top_tb.sv
